// ===== design/dtrq_pkg.sv =====
// shared types and codes for the dual timestamp reorder queue
package dtrq_pkg;

    localparam int STAMP_W  = 32;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int ENTRY_W  = STAMP_W + HANDLE_W;

    localparam logic [31:0] BUFFER_TIME_RST = 32'd100;

    // request codes on the func field
    typedef enum logic [2:0] {
        FN_PUSH_A = 3'd0,
        FN_PUSH_V = 3'd1,
        FN_POP_A  = 3'd2,
        FN_POP_V  = 3'd3,
        FN_CLEAR  = 3'd4
    } func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BUFFER_TIME   = 2'd0,
        REG_VIDEO_ENABLED = 2'd1,
        REG_AUDIO_ENABLED = 2'd2
    } reg_idx_t;

    // lane operations; none only clears the lane's per-request status
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } lane_op_t;

    // command from the top sequencer to one queue lane
    typedef struct packed {
        logic                start;
        lane_op_t            op;
        logic [STAMP_W-1:0]  stamp;
        logic [HANDLE_W-1:0] handle;
    } lane_cmd_t;

    // status of one queue lane
    typedef struct packed {
        logic                busy;
        logic                popped_valid;
        logic [STAMP_W-1:0]  popped_stamp;
        logic [HANDLE_W-1:0] popped_handle;
        logic                dropped;
        logic [STAMP_W-1:0]  front;
        logic [STAMP_W-1:0]  back;
    } lane_stat_t;

endpackage

// ===== design/dtrq_ram.sv =====
// generic simple dual port ram with registered read
module dtrq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/dtrq_lane.sv =====
// one sorted queue: circular buffer in ram with insertion scan from the back
module dtrq_lane
    import dtrq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lane_cmd_t                    cmd,
    output lane_stat_t                   stat,
    output logic [$clog2(DEPTH+1)-1:0]   fill
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        L_IDLE,
        L_SCAN,
        L_INS,
        L_POPRD,
        L_FRONT
    } lstate_t;

    lstate_t             state_reg;
    logic [AW-1:0]       head_reg;
    logic [CW-1:0]       fill_reg;
    logic [AW-1:0]       k_reg;
    logic [STAMP_W-1:0]  ts_reg;
    logic [HANDLE_W-1:0] h_reg;
    logic                pv_reg;
    logic [STAMP_W-1:0]  pstamp_reg;
    logic [HANDLE_W-1:0] phandle_reg;
    logic                drop_reg;
    logic [STAMP_W-1:0]  front_reg;
    logic [STAMP_W-1:0]  back_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [STAMP_W-1:0]  rd_stamp;
    logic                full;
    logic                empty;
    logic                shift_up;
    logic [AW-1:0]       last_idx;

    // logical index to physical slot, wrapping at the depth
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [AW-1:0] idx);
        logic [AW:0] s;
        s = {1'b0, hd} + {1'b0, idx};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    dtrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_stamp = ram_rdata[ENTRY_W-1:HANDLE_W];
    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign shift_up = (rd_stamp > ts_reg);
    assign last_idx = AW'(fill_reg - CW'(1));

    // ram port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = phys(head_reg, k_reg);
        ram_wdata = {ts_reg, h_reg};
        ram_raddr = head_reg;
        case (state_reg)
            L_IDLE:
            begin
                ram_wdata = {cmd.stamp, cmd.handle};
                ram_waddr = head_reg;
                if (cmd.start && cmd.op == OP_PUSH && !full)
                begin
                    if (empty)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        ram_raddr = phys(head_reg, last_idx);
                    end
                end
            end
            L_SCAN:
            begin
                ram_we = 1'b1;
                if (shift_up)
                begin
                    ram_wdata = ram_rdata;
                    ram_raddr = phys(head_reg, k_reg - AW'(1) - AW'(1));
                end
            end
            L_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = head_reg;
            end
            L_POPRD:
            begin
                ram_raddr = phys(head_reg, AW'(1));
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer and queue bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            pv_reg    <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                L_IDLE:
                begin
                    if (cmd.start)
                    begin
                        pv_reg      <= 1'b0;
                        drop_reg    <= 1'b0;
                        pstamp_reg  <= '0;
                        phandle_reg <= '0;
                        ts_reg      <= cmd.stamp;
                        h_reg       <= cmd.handle;
                        case (cmd.op)
                            OP_PUSH:
                            begin
                                if (full)
                                begin
                                    drop_reg <= 1'b1;
                                end
                                else if (empty)
                                begin
                                    front_reg <= cmd.stamp;
                                    back_reg  <= cmd.stamp;
                                    fill_reg  <= fill_reg + CW'(1);
                                end
                                else
                                begin
                                    k_reg     <= fill_reg[AW-1:0];
                                    state_reg <= L_SCAN;
                                end
                            end
                            OP_POP:
                            begin
                                if (!empty)
                                begin
                                    state_reg <= L_POPRD;
                                end
                            end
                            OP_CLEAR:
                            begin
                                fill_reg <= '0;
                                head_reg <= '0;
                            end
                            default:
                            begin
                                state_reg <= L_IDLE;
                            end
                        endcase
                    end
                end
                L_SCAN:
                begin
                    if (shift_up)
                    begin
                        k_reg <= k_reg - AW'(1);
                        if (k_reg == AW'(1))
                        begin
                            state_reg <= L_INS;
                        end
                    end
                    else
                    begin
                        if (CW'(k_reg) == fill_reg)
                        begin
                            back_reg <= ts_reg;
                        end
                        fill_reg  <= fill_reg + CW'(1);
                        state_reg <= L_IDLE;
                    end
                end
                L_INS:
                begin
                    front_reg <= ts_reg;
                    fill_reg  <= fill_reg + CW'(1);
                    state_reg <= L_IDLE;
                end
                L_POPRD:
                begin
                    pv_reg      <= 1'b1;
                    pstamp_reg  <= rd_stamp;
                    phandle_reg <= ram_rdata[HANDLE_W-1:0];
                    head_reg    <= phys(head_reg, AW'(1));
                    fill_reg    <= fill_reg - CW'(1);
                    if (fill_reg == CW'(1))
                    begin
                        state_reg <= L_IDLE;
                    end
                    else
                    begin
                        state_reg <= L_FRONT;
                    end
                end
                L_FRONT:
                begin
                    front_reg <= rd_stamp;
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign stat.busy          = (state_reg != L_IDLE);
    assign stat.popped_valid  = pv_reg;
    assign stat.popped_stamp  = pstamp_reg;
    assign stat.popped_handle = phandle_reg;
    assign stat.dropped       = drop_reg;
    assign stat.front         = front_reg;
    assign stat.back          = back_reg;
    assign fill               = fill_reg;

endmodule

// ===== design/dual_timestamp_reorder_queue_core.sv =====
// top level: request sequencing, span and front reporting, output register
// from accept to result beat: T_LANE waits until both lanes are idle, T_SPAN registers the spans,
// T_FIN registers the result beat and holds while an earlier beat is stalled; a push into a
// non-empty queue shifts entries up from the back, a pop reads the front and then the new front
// throughput: one request at a time, the next taken the cycle after a result is registered
// reset: both queues empty, buffer_time 100, both stream enables 0; ram contents are not cleared
module dual_timestamp_reorder_queue_core
    import dtrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          func,
    input  logic [STAMP_W-1:0]  stamp,
    input  logic [HANDLE_W-1:0] frame_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                popped_valid,
    output logic [HANDLE_W-1:0] popped_handle,
    output logic [STAMP_W-1:0]  popped_stamp,
    output logic                push_dropped,
    output logic [STAMP_W-1:0]  span_ms,
    output logic                over_limit,
    output logic                next_valid,
    output logic [STAMP_W-1:0]  next_stamp,
    output logic [COUNT_W-1:0]  audio_count,
    output logic [COUNT_W-1:0]  video_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        T_IDLE,
        T_LANE,
        T_SPAN,
        T_FIN
    } tstate_t;

    tstate_t             state_reg;
    logic [31:0]         buffer_time_reg;
    logic                video_en_reg;
    logic                audio_en_reg;
    logic [STAMP_W-1:0]  asp_reg;
    logic [STAMP_W-1:0]  vsp_reg;

    logic                out_valid_reg;
    logic                pv_reg;
    logic [HANDLE_W-1:0] ph_reg;
    logic [STAMP_W-1:0]  ps_reg;
    logic                drop_reg;
    logic [STAMP_W-1:0]  span_reg;
    logic                over_reg;
    logic                nv_reg;
    logic [STAMP_W-1:0]  ns_reg;
    logic [COUNT_W-1:0]  acnt_reg;
    logic [COUNT_W-1:0]  vcnt_reg;

    lane_cmd_t           a_cmd;
    lane_cmd_t           v_cmd;
    lane_stat_t          a_stat;
    lane_stat_t          v_stat;
    logic [CW-1:0]       a_fill;
    logic [CW-1:0]       v_fill;
    logic                accept;
    logic [STAMP_W-1:0]  span_next;
    logic                nv_next;
    logic [STAMP_W-1:0]  ns_next;

    assign in_ready = (state_reg == T_IDLE);
    assign accept   = in_valid && in_ready;

    // request decode into lane commands; both lanes start so stale status is cleared
    always_comb
    begin
        a_cmd.start  = accept;
        a_cmd.op     = OP_NONE;
        a_cmd.stamp  = stamp;
        a_cmd.handle = frame_handle;
        v_cmd        = a_cmd;
        case (func)
            FN_PUSH_A:
            begin
                a_cmd.op    = OP_PUSH;
            end
            FN_PUSH_V:
            begin
                v_cmd.op    = OP_PUSH;
            end
            FN_POP_A:
            begin
                a_cmd.op    = OP_POP;
            end
            FN_POP_V:
            begin
                v_cmd.op    = OP_POP;
            end
            FN_CLEAR:
            begin
                a_cmd.op    = OP_CLEAR;
                v_cmd.op    = OP_CLEAR;
            end
            default:
            begin
                a_cmd.op    = OP_NONE;
            end
        endcase
    end

    dtrq_lane #(
        .DEPTH (QUEUE_DEPTH)
    ) u_audio (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (a_cmd),
        .stat  (a_stat),
        .fill  (a_fill)
    );

    dtrq_lane #(
        .DEPTH (QUEUE_DEPTH)
    ) u_video (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (v_cmd),
        .stat  (v_stat),
        .fill  (v_fill)
    );

    // span selection and earliest front
    always_comb
    begin
        if (video_en_reg && audio_en_reg)
        begin
            span_next = (asp_reg < vsp_reg) ? asp_reg : vsp_reg;
        end
        else if (video_en_reg)
        begin
            span_next = vsp_reg;
        end
        else if (audio_en_reg)
        begin
            span_next = asp_reg;
        end
        else
        begin
            span_next = '0;
        end
        nv_next = (a_fill != '0) || (v_fill != '0);
        ns_next = '0;
        if (a_fill != '0)
        begin
            ns_next = a_stat.front;
        end
        if (v_fill != '0)
        begin
            if (a_fill == '0 || v_stat.front < a_stat.front)
            begin
                ns_next = v_stat.front;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_time_reg <= BUFFER_TIME_RST;
            video_en_reg    <= 1'b0;
            audio_en_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUFFER_TIME:   buffer_time_reg <= cfg_data;
                REG_VIDEO_ENABLED: video_en_reg    <= cfg_data[0];
                REG_AUDIO_ENABLED: audio_en_reg    <= cfg_data[0];
                default:           buffer_time_reg <= buffer_time_reg;
            endcase
        end
    end

    // sequencer and result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != T_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= T_LANE;
                    end
                end
                T_LANE:
                begin
                    if (!a_stat.busy && !v_stat.busy)
                    begin
                        state_reg <= T_SPAN;
                    end
                end
                T_SPAN:
                begin
                    asp_reg   <= (a_fill == '0) ? '0 : a_stat.back - a_stat.front;
                    vsp_reg   <= (v_fill == '0) ? '0 : v_stat.back - v_stat.front;
                    state_reg <= T_FIN;
                end
                T_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        pv_reg   <= a_stat.popped_valid | v_stat.popped_valid;
                        ph_reg   <= a_stat.popped_handle | v_stat.popped_handle;
                        ps_reg   <= a_stat.popped_stamp | v_stat.popped_stamp;
                        drop_reg <= a_stat.dropped | v_stat.dropped;
                        span_reg <= span_next;
                        over_reg <= (span_next > buffer_time_reg);
                        nv_reg   <= nv_next;
                        ns_reg   <= ns_next;
                        acnt_reg <= COUNT_W'(a_fill);
                        vcnt_reg <= COUNT_W'(v_fill);
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign popped_valid  = pv_reg;
    assign popped_handle = ph_reg;
    assign popped_stamp  = ps_reg;
    assign push_dropped  = drop_reg;
    assign span_ms       = span_reg;
    assign over_limit    = over_reg;
    assign next_valid    = nv_reg;
    assign next_stamp    = ns_reg;
    assign audio_count   = acnt_reg;
    assign video_count   = vcnt_reg;

    // fill counts never pass the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_fill <= CW'(QUEUE_DEPTH)) && (v_fill <= CW'(QUEUE_DEPTH)))
        else $error("queue fill beyond depth");

    // a request closes the input until its result is formed
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken while busy");

    // a result never reports both a pop and a dropped push
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(popped_valid && push_dropped))
        else $error("pop and drop in one result");

    // lanes only start while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_cmd.start || v_cmd.start) |-> (!a_stat.busy && !v_stat.busy))
        else $error("lane started while busy");

endmodule

// ===== bench/dual_timestamp_reorder_queue_core_tb.sv =====
// testbench for the dual timestamp reorder queue core
`timescale 1ns / 100ps

module dual_timestamp_reorder_queue_core_tb;
    import dtrq_pkg::*;

    localparam int DEPTH = 64;

    typedef struct {
        logic                pvalid;
        logic [HANDLE_W-1:0] phandle;
        logic [STAMP_W-1:0]  pstamp;
        logic                dropped;
        logic [STAMP_W-1:0]  span;
        logic                over;
        logic                nvalid;
        logic [STAMP_W-1:0]  nstamp;
        logic [COUNT_W-1:0]  acount;
        logic [COUNT_W-1:0]  vcount;
    } status_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [2:0]          func = '0;
    logic [STAMP_W-1:0]  stamp = '0;
    logic [HANDLE_W-1:0] frame_handle = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                popped_valid;
    logic [HANDLE_W-1:0] popped_handle;
    logic [STAMP_W-1:0]  popped_stamp;
    logic                push_dropped;
    logic [STAMP_W-1:0]  span_ms;
    logic                over_limit;
    logic                next_valid;
    logic [STAMP_W-1:0]  next_stamp;
    logic [COUNT_W-1:0]  audio_count;
    logic [COUNT_W-1:0]  video_count;

    // predictor state
    logic [STAMP_W-1:0]  a_stamps [DEPTH];
    logic [HANDLE_W-1:0] a_handles [DEPTH];
    int                  a_fill = 0;
    logic [STAMP_W-1:0]  v_stamps [DEPTH];
    logic [HANDLE_W-1:0] v_handles [DEPTH];
    int                  v_fill = 0;
    logic [31:0]         buf_time = BUFFER_TIME_RST;
    logic                vid_en = 1'b0;
    logic                aud_en = 1'b0;

    status_t pending_status [$];
    int      errors = 0;
    int      hold_off = 0;   // cycles the receiver must stall
    int      stall_req = 0;  // long hold-offs asked for by a test
    int      stall_done = 0; // long hold-offs started by the receiver

    dual_timestamp_reorder_queue_core #(.QUEUE_DEPTH(DEPTH)) u_dut (.*);

    always #4 clk = ~clk;

    // sorted insertion; returns 0 when the queue is full
    function automatic bit insert_sorted(ref logic [STAMP_W-1:0] st [DEPTH],
                                         ref logic [HANDLE_W-1:0] hd [DEPTH],
                                         ref int fill, input logic [STAMP_W-1:0] ts,
                                         input logic [HANDLE_W-1:0] h);
        int pos;
        if (fill >= DEPTH)
            return 0;
        pos = fill;
        while (pos > 0 && st[pos-1] > ts)
            pos--;
        for (int k = fill; k > pos; k--)
        begin
            st[k] = st[k-1];
            hd[k] = hd[k-1];
        end
        st[pos] = ts;
        hd[pos] = h;
        fill++;
        return 1;
    endfunction

    function automatic bit remove_front(ref logic [STAMP_W-1:0] st [DEPTH],
                                        ref logic [HANDLE_W-1:0] hd [DEPTH],
                                        ref int fill, ref status_t r);
        if (fill == 0)
            return 0;
        r.pstamp  = st[0];
        r.phandle = hd[0];
        for (int k = 1; k < fill; k++)
        begin
            st[k-1] = st[k];
            hd[k-1] = hd[k];
        end
        fill--;
        return 1;
    endfunction

    // predict the status beat for one request
    function automatic status_t predict_status(logic [2:0] f, logic [STAMP_W-1:0] ts,
                                               logic [HANDLE_W-1:0] h);
        status_t r;
        logic [STAMP_W-1:0] asp, vsp;
        r = '{default: '0};
        case (f)
            FN_PUSH_A: r.dropped = !insert_sorted(a_stamps, a_handles, a_fill, ts, h);
            FN_PUSH_V: r.dropped = !insert_sorted(v_stamps, v_handles, v_fill, ts, h);
            FN_POP_A:  r.pvalid = remove_front(a_stamps, a_handles, a_fill, r);
            FN_POP_V:  r.pvalid = remove_front(v_stamps, v_handles, v_fill, r);
            FN_CLEAR:
            begin
                a_fill = 0;
                v_fill = 0;
            end
            default: ;
        endcase
        if (!r.pvalid)
        begin
            r.pstamp = '0;
            r.phandle = '0;
        end
        asp = (a_fill == 0) ? '0 : a_stamps[a_fill-1] - a_stamps[0];
        vsp = (v_fill == 0) ? '0 : v_stamps[v_fill-1] - v_stamps[0];
        if (vid_en && aud_en)
            r.span = (asp < vsp) ? asp : vsp;
        else if (vid_en)
            r.span = vsp;
        else if (aud_en)
            r.span = asp;
        else
            r.span = '0;
        r.over = r.span > buf_time;
        if (a_fill > 0)
        begin
            r.nvalid = 1'b1;
            r.nstamp = a_stamps[0];
        end
        if (v_fill > 0)
        begin
            if (!r.nvalid || v_stamps[0] < r.nstamp)
                r.nstamp = v_stamps[0];
            r.nvalid = 1'b1;
        end
        r.acount = a_fill[COUNT_W-1:0];
        r.vcount = v_fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // send one request beat and record its expected status
    task automatic send_request(logic [2:0] f, logic [STAMP_W-1:0] ts,
                                logic [HANDLE_W-1:0] h, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        stamp        <= ts;
        frame_handle <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_status.push_back(predict_status(f, ts, h));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_BUFFER_TIME:   buf_time = val;
            REG_VIDEO_ENABLED: vid_en = val[0];
            REG_AUDIO_ENABLED: aud_en = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] bt, bit v, bit a);
        wait_idle();
        write_reg(REG_BUFFER_TIME, bt);
        write_reg(REG_VIDEO_ENABLED, {31'd0, v});
        write_reg(REG_AUDIO_ENABLED, {31'd0, a});
        cfg_we <= 1'b0;
    endtask

    // receiver: random stalls, plus a forced long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (stall_done != stall_req)
        begin
            stall_done <= stall_req;
            hold_off <= 400;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            hold_off <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // status checker
    always @(posedge clk)
    begin
        status_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: unexpected status beat", $time);
                errors++;
            end
            else
            begin
                e = pending_status[0];
                pending_status.delete(0);
                if ({popped_valid, popped_handle, popped_stamp, push_dropped, span_ms,
                     over_limit, next_valid, next_stamp, audio_count, video_count} !==
                    {e.pvalid, e.phandle, e.pstamp, e.dropped, e.span, e.over,
                     e.nvalid, e.nstamp, e.acount, e.vcount})
                begin
                    $display("%0t: mismatch expected pv=%0d ph=%h ps=%h dr=%0d span=%h ov=%0d nv=%0d ns=%h ac=%0d vc=%0d",
                             $time, e.pvalid, e.phandle, e.pstamp, e.dropped, e.span,
                             e.over, e.nvalid, e.nstamp, e.acount, e.vcount);
                    $display("%0t:          actual   pv=%0d ph=%h ps=%h dr=%0d span=%h ov=%0d nv=%0d ns=%h ac=%0d vc=%0d",
                             $time, popped_valid, popped_handle, popped_stamp,
                             push_dropped, span_ms, over_limit, next_valid, next_stamp,
                             audio_count, video_count);
                    errors++;
                end
            end
        end
    end

    // directed: empty pops, extremes, equal stamps, unused codes, clear
    task automatic test_directed();
        send_request(FN_POP_A, 32'hFFFFFFFF, 16'hFFFF);
        send_request(FN_POP_V, 32'h0, 16'h0);
        send_request(FN_PUSH_A, 32'hFFFFFFFF, 16'hFFFF);
        send_request(FN_PUSH_A, 32'h0, 16'h0001);
        send_request(FN_PUSH_A, 32'h0, 16'h0002);
        send_request(FN_PUSH_V, 32'h8000_0000, 16'h8000);
        send_request(FN_PUSH_V, 32'h0000_0050, 16'h1234);
        send_request(FN_PUSH_V, 32'h0000_0050, 16'h5678);
        send_request(3'd5, 32'h1, 16'h1);
        send_request(3'd6, 32'h2, 16'h2);
        send_request(3'd7, 32'hFFFFFFFF, 16'hFFFF);
        send_request(FN_POP_A, 32'h0, 16'h0);
        send_request(FN_POP_V, 32'h0, 16'h0);
        send_request(FN_CLEAR, 32'h0, 16'h0);
        send_request(FN_POP_A, 32'h0, 16'h0);
    endtask

    // fill both queues past full so pushes drop
    task automatic test_full_queue();
        for (int i = 0; i < DEPTH + 3; i++)
            send_request(FN_PUSH_A, STAMP_W'($urandom_range(0, 200)), HANDLE_W'($urandom), 1);
        for (int i = 0; i < DEPTH + 3; i++)
            send_request(FN_PUSH_V, STAMP_W'($urandom), HANDLE_W'($urandom), 1);
        for (int i = 0; i < 5; i++)
            send_request(FN_POP_V, '0, '0);
        send_request(FN_CLEAR, '0, '0);
    endtask

    // receiver stalls long while requests keep coming
    task automatic test_backpressure();
        wait_idle();
        stall_req++;
        for (int i = 0; i < 20; i++)
            send_request(3'($urandom_range(0, 1)), STAMP_W'($urandom_range(0, 1000)),
                         HANDLE_W'($urandom), 1);
        send_request(FN_CLEAR, '0, '0);
    endtask

    // random mix, biased to keep queues part full
    task automatic test_random(int count);
        logic [2:0] f;
        logic [STAMP_W-1:0] ts;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)      f = FN_PUSH_A;
            else if (r < 60) f = FN_PUSH_V;
            else if (r < 75) f = FN_POP_A;
            else if (r < 90) f = FN_POP_V;
            else if (r < 93) f = FN_CLEAR;
            else             f = 3'($urandom_range(5, 7));
            ts = ($urandom_range(0, 3) == 0) ? STAMP_W'($urandom)
                                             : STAMP_W'($urandom_range(0, 300));
            send_request(f, ts, HANDLE_W'($urandom));
        end
    endtask

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        set_config(32'd0, 1'b1, 1'b1);
        test_directed();
        set_config(32'hFFFFFFFF, 1'b1, 1'b0);
        test_full_queue();
        set_config(32'd100, 1'b0, 1'b1);
        test_backpressure();
        set_config(32'd150, 1'b1, 1'b1);
        test_random(450);
        set_config(32'd0, 1'b0, 1'b1);
        test_random(350);
        set_config($urandom, 1'b1, 1'b0);
        test_random(350);
        set_config(32'd50, 1'b0, 1'b0);
        test_random(300);
        wait_idle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== dual_timestamp_reorder_queue_core.f =====
design/dtrq_pkg.sv
design/dtrq_ram.sv
design/dtrq_lane.sv
design/dual_timestamp_reorder_queue_core.sv
bench/dual_timestamp_reorder_queue_core_tb.sv
